>>> sv/sdsq_pkg.sv
// ----------------------------------------------------------------------------
// sdsq_pkg
// Shared types, constants and helpers for the sprite depth sort queue.
// ----------------------------------------------------------------------------
package sdsq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int HANDLE_BITS = 16;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int SUM_W   = PTR_W + 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LAYER_W = 8;
  localparam int BOT_W   = 18;
  localparam int ENTRY_W = HANDLE_BITS + LAYER_W + BOT_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [15:0]         sprite_handle;
    logic [7:0]          layer;
    logic signed [15:0]  top_y;
    logic [11:0]         height;
  } req_t;

  typedef struct packed {
    logic [15:0] out_handle;
    logic        out_valid;
    logic        rejected;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [LAYER_W-1:0]     layer;
    logic signed [BOT_W-1:0] bottom;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_PLACE,
    S_POP,
    S_DONE
  } state_t;

  // physical slot of a logical queue position in the circular store
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> sv/sdsq_ram.sv
// ----------------------------------------------------------------------------
// sdsq_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sdsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/sdsq_key_cmp.sv
// ----------------------------------------------------------------------------
// sdsq_key_cmp
// Draw key comparator: layer first, then signed bottom edge.
// ----------------------------------------------------------------------------
module sdsq_key_cmp (
  input  sdsq_pkg::entry_t a,
  input  sdsq_pkg::entry_t b,
  output logic             a_greater
);

  import sdsq_pkg::*;

  always_comb begin
    if (a.layer != b.layer) begin
      a_greater = a.layer > b.layer;
    end else begin
      a_greater = a.bottom > b.bottom;
    end
  end

endmodule

>>> sv/sprite_depth_sort_queue_unit.sv
// ----------------------------------------------------------------------------
// sprite_depth_sort_queue_unit
// Stable sorted draw queue held in a circular RAM. Inserts scan back from the
// tail, moving greater entries up one slot per cycle; pops advance the head.
// ----------------------------------------------------------------------------
// sequence: clear, no-op, rejected ops and insert into an empty queue go from
//   the start state straight to done; pop reads the head in a pop state;
//   other inserts scan past each greater stored entry and write the new one
// throughput: one transaction at a time, the next accepted the cycle after
//   the result is registered; the insert scan does one RAM read per cycle
// reset: synchronous, clears fill count, head pointer and output valid at
//   once; the entry RAM is not cleared, unused slots are never read
module sprite_depth_sort_queue_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sdsq_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output sdsq_pkg::rsp_t  rsp
);

  import sdsq_pkg::*;

  state_t                 state, state_next;
  logic [PTR_W-1:0]       head, head_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [PTR_W-1:0]       idx, idx_next;
  op_t                    op, op_next;
  entry_t                 item, item_next;
  logic [HANDLE_BITS-1:0] res_handle, res_handle_next;
  logic                   res_hit, res_hit_next;
  logic                   res_rej, res_rej_next;
  rsp_t                   rsp_next;
  logic                   rsp_valid_next;

  logic                   wr_en, rd_en;
  logic [PTR_W-1:0]       wr_addr, rd_addr;
  entry_t                 wr_data, rd_data;
  logic                   entry_gt;

  sdsq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sdsq_key_cmp u_cmp (
    .a         (rd_data),
    .b         (item),
    .a_greater (entry_gt)
  );

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
    idx        <= idx_next;
    op         <= op_next;
    item       <= item_next;
    res_handle <= res_handle_next;
    res_hit    <= res_hit_next;
    res_rej    <= res_rej_next;
    rsp        <= rsp_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    idx_next        = idx;
    op_next         = op;
    item_next       = item;
    res_handle_next = res_handle;
    res_hit_next    = res_hit;
    res_rej_next    = res_rej;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    wr_en           = 1'b0;
    wr_addr         = head;
    wr_data         = item;
    rd_en           = 1'b0;
    rd_addr         = head;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next          = req.operation;
          item_next.handle = HANDLE_BITS'(req.sprite_handle);
          item_next.layer  = req.layer;
          item_next.bottom = BOT_W'(req.top_y) + BOT_W'({1'b0, req.height});
          res_handle_next  = '0;
          res_hit_next     = 1'b0;
          res_rej_next     = 1'b0;
          state_next       = S_START;
        end
      end
      S_START: begin
        case (op)
          OP_INSERT: begin
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              res_rej_next = 1'b1;
              state_next   = S_DONE;
            end else if (count == '0) begin
              wr_en      = 1'b1;
              wr_addr    = head;
              count_next = count + CNT_W'(1);
              state_next = S_DONE;
            end else begin
              idx_next   = PTR_W'(count - CNT_W'(1));
              rd_en      = 1'b1;
              rd_addr    = slot(head, PTR_W'(count - CNT_W'(1)));
              state_next = S_SCAN;
            end
          end
          OP_POP: begin
            if (count == '0) begin
              res_rej_next = 1'b1;
              state_next   = S_DONE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head;
              state_next = S_POP;
            end
          end
          OP_CLEAR: begin
            count_next = '0;
            state_next = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // rd_data holds the entry at idx, read in the previous cycle
        wr_en   = 1'b1;
        wr_addr = slot(head, PTR_W'(idx + PTR_W'(1)));
        if (entry_gt) begin
          wr_data = rd_data;
          if (idx == '0) begin
            state_next = S_PLACE;
          end else begin
            idx_next = idx - PTR_W'(1);
            rd_en    = 1'b1;
            rd_addr  = slot(head, PTR_W'(idx - PTR_W'(1)));
          end
        end else begin
          wr_data    = item;
          count_next = count + CNT_W'(1);
          state_next = S_DONE;
        end
      end
      S_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = head;
        count_next = count + CNT_W'(1);
        state_next = S_DONE;
      end
      S_POP: begin
        res_handle_next = rd_data.handle;
        res_hit_next    = 1'b1;
        head_next       = slot(head, PTR_W'(1));
        count_next      = count - CNT_W'(1);
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.out_handle  = 16'(32'(res_handle));
          rsp_next.out_valid   = res_hit;
          rsp_next.rejected    = res_rej;
          rsp_next.entry_count = 7'(32'(count));
          rsp_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/sdsq_checker.sv
// ----------------------------------------------------------------------------
// sdsq_checker
// Port-level checks for the sprite depth sort queue, bound to the top level.
// ----------------------------------------------------------------------------
module sdsq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input sdsq_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input sdsq_pkg::rsp_t rsp
);

  import sdsq_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  a_hit_not_rejected: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.out_valid && rsp.rejected))
    else $error("pop both returned and rejected");

  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.out_valid |-> rsp.out_handle == 16'd0)
    else $error("handle nonzero without a popped entry");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind sprite_depth_sort_queue_unit sdsq_checker u_sdsq_checker (.*);

>>> tb/depth_order_checker.sv
// ----------------------------------------------------------------------------
// depth_order_checker
// Watches both channels of the sprite depth sort queue. It keeps its own
// painter's-order list and predicts one response for each request transaction.
// Each response transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module depth_order_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  sdsq_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  sdsq_pkg::rsp_t rsp,
  output int             mismatches,
  output int             outstanding
);

  import sdsq_pkg::*;

  entry_t draw_list [QUEUE_DEPTH];
  int     held = 0;
  rsp_t   pending_results [$];
  rsp_t   want;

  // a stored entry goes behind the new one when its layer is higher, or its
  // layer is equal and its bottom edge is lower on screen
  function automatic logic drawn_after(entry_t stored, logic [LAYER_W-1:0] lay,
                                       logic signed [BOT_W-1:0] bot);
    if (stored.layer != lay) begin
      return stored.layer > lay;
    end
    return $signed(stored.bottom) > $signed(bot);
  endfunction

  function automatic rsp_t apply_draw_op(req_t r);
    rsp_t   res;
    entry_t fresh;
    int     pos;
    res = '0;
    case (r.operation)
      OP_INSERT: begin
        if (held >= QUEUE_DEPTH) begin
          res.rejected = 1'b1;
        end else begin
          fresh.handle = r.sprite_handle[HANDLE_BITS-1:0];
          fresh.layer  = r.layer;
          fresh.bottom = {{2{r.top_y[15]}}, r.top_y} + {6'd0, r.height};
          pos = held;
          for (int i = 0; i < held; i++) begin
            if (pos == held && drawn_after(draw_list[i], fresh.layer, fresh.bottom)) begin
              pos = i;
            end
          end
          for (int i = held; i > pos; i--) begin
            draw_list[i] = draw_list[i-1];
          end
          draw_list[pos] = fresh;
          held++;
        end
      end
      OP_POP: begin
        if (held == 0) begin
          res.rejected = 1'b1;
        end else begin
          res.out_handle = 16'(draw_list[0].handle);
          res.out_valid  = 1'b1;
          for (int i = 1; i < held; i++) begin
            draw_list[i-1] = draw_list[i];
          end
          held--;
        end
      end
      OP_CLEAR: begin
        held = 0;
      end
      default: begin
        // unused code, queue untouched
      end
    endcase
    res.entry_count = 7'(held);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held = 0;
      pending_results.delete();
    end else begin
      // response first: its request was accepted at an earlier edge
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected response: handle %h valid %b rej %b count %0d",
                     $time, rsp.out_handle, rsp.out_valid, rsp.rejected, rsp.entry_count);
          end
        end else begin
          want = pending_results.pop_front();
          if (rsp.out_handle !== want.out_handle || rsp.out_valid !== want.out_valid ||
              rsp.rejected !== want.rejected || rsp.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch: exp handle %h valid %b rej %b count %0d",
                       $time, want.out_handle, want.out_valid, want.rejected,
                       want.entry_count);
              $display("[%0t]           got handle %h valid %b rej %b count %0d",
                       $time, rsp.out_handle, rsp.out_valid, rsp.rejected,
                       rsp.entry_count);
            end
          end
        end
      end
      if (req_valid && req_ready) begin
        pending_results.push_back(apply_draw_op(req));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

>>> tb/sprite_depth_sort_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// sprite_depth_sort_queue_unit_tb
// Drives insert, pop, clear and unused operation codes into the sort queue.
// A directed opener covers field extremes, ties and empty-queue corners. Then
// random fill, drain and mixed segments follow, with bursts of idling on both
// channels. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module sprite_depth_sort_queue_unit_tb;
  import sdsq_pkg::*;

  localparam int         CLK_PERIOD   = 10;
  localparam int         RANDOM_ITEMS = 1730;
  localparam int         TAIL_ITEMS   = 200;
  localparam int         DRAIN_CYCLES = QUEUE_DEPTH + 16;
  localparam logic [1:0] OP_NOP       = 2'd3;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  int mismatches;
  int outstanding;
  bit idle_on = 1'b0;

  sprite_depth_sort_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  depth_order_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 1000000);
    $display("CHECKS FAILED");
    $finish;
  end

  // response side backpressure
  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
    end
  end

  task automatic issue(input logic [1:0] op, input logic [15:0] hnd, input logic [7:0] lay,
                       input logic [15:0] ty, input logic [11:0] ht);
    req_t r;
    r.operation     = op_t'(op);
    r.sprite_handle = hnd;
    r.layer         = lay;
    r.top_y         = ty;
    r.height        = ht;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // keys mostly drawn from a narrow range so ties and reorders are frequent
  task automatic random_draw_op(input int mode);
    int         roll;
    logic [1:0] op;
    logic [7:0] lay;
    logic [15:0] ty;
    logic [11:0] ht;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  op = (roll < 85) ? OP_INSERT : (roll < 98) ? OP_POP :
                       (roll < 99) ? OP_CLEAR : OP_NOP;
      MODE_DRAIN: op = (roll < 15) ? OP_INSERT : (roll < 97) ? OP_POP :
                       (roll < 98) ? OP_CLEAR : OP_NOP;
      default:    op = (roll < 50) ? OP_INSERT : (roll < 97) ? OP_POP :
                       (roll < 98) ? OP_CLEAR : OP_NOP;
    endcase
    lay = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    ty  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16) - 8);
    ht  = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 7));
    issue(op, 16'($urandom), lay, ty, ht);
  endtask

  initial begin
    int sent;
    int seg_len;
    int mode;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (11) @(posedge clk);
    rst     <= 1'b0;
    idle_on = 1'b1;

    // empty queue corners
    issue(OP_POP,    16'h1234, 8'd0,   16'h0000, 12'd0);
    issue(OP_NOP,    16'hffff, 8'hff,  16'hffff, 12'hfff);
    // extremes of every key field, with equal keys kept in arrival order
    issue(OP_INSERT, 16'hffff, 8'd255, 16'h7fff, 12'd4095);
    issue(OP_INSERT, 16'h0000, 8'd0,   16'h8000, 12'd0);
    issue(OP_INSERT, 16'h0001, 8'd0,   16'h8000, 12'd0);
    issue(OP_INSERT, 16'h0002, 8'd255, 16'h7fff, 12'd4095);
    issue(OP_INSERT, 16'h0003, 8'd7,   16'd100,  12'd20);
    issue(OP_INSERT, 16'h0004, 8'd7,   16'd110,  12'd10);
    issue(OP_INSERT, 16'h0005, 8'd7,   16'd119,  12'd0);
    issue(OP_INSERT, 16'h0006, 8'd7,   16'hfff0, 12'd200);
    issue(OP_NOP,    16'h0000, 8'd0,   16'h0000, 12'd0);
    repeat (9) begin
      issue(OP_POP, 16'h0000, 8'd0, 16'h0000, 12'd0);
    end
    issue(OP_INSERT, 16'haaaa, 8'h55,  16'h5555, 12'haaa);
    issue(OP_CLEAR,  16'h5555, 8'haa,  16'haaaa, 12'h555);
    issue(OP_POP,    16'h0000, 8'd0,   16'h0000, 12'd0);
    issue(OP_CLEAR,  16'h0000, 8'd0,   16'h0000, 12'd0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(30, 120);
      mode    = $urandom_range(MODE_FILL, MODE_MIX);
      idle_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        if (sent >= RANDOM_ITEMS - TAIL_ITEMS) begin
          idle_on = 1'b0;
        end
        random_draw_op(mode);
        sent++;
      end
    end
    req_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sprite_depth_sort_queue_unit.f
sv/sdsq_pkg.sv
sv/sdsq_ram.sv
sv/sdsq_key_cmp.sv
sv/sprite_depth_sort_queue_unit.sv
sv/sdsq_checker.sv
tb/depth_order_checker.sv
tb/sprite_depth_sort_queue_unit_tb.sv
